// ----- sv/counting_semaphore_table_defines.svh -----
// assertion helpers for the semaphore table
`ifndef COUNTING_SEMAPHORE_TABLE_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CST_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CST_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CST_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define CST_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- sv/cst_pkg.sv -----
package cst_pkg;

    // widest slot number the table can be built with
    localparam int SLOT_MAX_W = 8;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_UP      = 2'd1,
        CMD_DOWN    = 2'd2,
        CMD_RECLAIM = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DONE
    } state_t;

    // requests into the slot allocator
    typedef struct packed {
        logic                  set;
        logic                  clr;
        logic [SLOT_MAX_W-1:0] slot;
        logic [SLOT_MAX_W-1:0] query;
    } alloc_req_t;

    // allocator status back to the control
    typedef struct packed {
        logic                  full;
        logic                  hit;
        logic [SLOT_MAX_W-1:0] free_slot;
    } alloc_stat_t;

endpackage

// ----- sv/cst_ram.sv -----
module cst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/cst_alloc.sv -----
module cst_alloc #(
    parameter int NUM_SEMS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cst_pkg::alloc_req_t  req,
    output cst_pkg::alloc_stat_t stat
);

    localparam int SLOT_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

    logic [NUM_SEMS-1:0] valid_reg;
    logic [NUM_SEMS-1:0] valid_next;
    logic [SLOT_W-1:0]   free_slot;

    // set on init, clear on reclaim
    always_comb begin
        valid_next = valid_reg;
        if (req.set) begin
            valid_next[SLOT_W'(req.slot)] = 1'b1;
        end
        if (req.clr) begin
            valid_next[SLOT_W'(req.slot)] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = NUM_SEMS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign stat.full      = &valid_reg;
    assign stat.free_slot = cst_pkg::SLOT_MAX_W'(free_slot);
    assign stat.hit       = (32'(req.query) < NUM_SEMS) && valid_reg[SLOT_W'(req.query)];

endmodule

// ----- sv/counting_semaphore_table.sv -----
// Counting semaphore table: one command word in, one result word out.
// A word passes through the slot row read, the wait queue read and the output register in turn.
// A new word is taken only in the idle state, after the slot row read-modify-write
// and the wait queue read of the last word, and not while m_ready holds a result back.
// Reset: synchronous, active low; empties the slot table and the output register.
// Row and queue memories are not cleared; init writes a slot's whole row.
`include "counting_semaphore_table_defines.svh"

module counting_semaphore_table #(
    parameter int NUM_SEMS   = 16,
    parameter int NUM_PROCS  = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [3:0] s_sem_index,
    input  logic [4:0] s_process_id,
    input  logic [7:0] s_init_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_status,
    output logic [3:0] m_assigned_index,
    output logic       m_blocked,
    output logic       m_woken_valid,
    output logic [4:0] m_woken_process
);

    localparam int SLOT_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int PID_W      = $clog2(NUM_PROCS);
    localparam int CNT_W      = ((COUNT_BITS > PID_W) ? COUNT_BITS : PID_W) + 2;
    localparam int ROW_W      = CNT_W + COUNT_BITS + 2 * PID_W + NUM_PROCS;
    localparam int ROW_DEPTH  = 2 ** SLOT_W;
    localparam int WAIT_AW    = SLOT_W + PID_W;
    localparam int WAIT_DEPTH = 2 ** WAIT_AW;
    localparam logic signed [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [PID_W-1:0]        PTR_LAST = PID_W'(NUM_PROCS - 1);

    typedef struct packed {
        logic signed [CNT_W-1:0] count;
        logic [COUNT_BITS-1:0]   max;
        logic [PID_W-1:0]        head;
        logic [PID_W-1:0]        tail;
        logic [NUM_PROCS-1:0]    owners;
    } row_t;

    cst_pkg::state_t      state_reg, state_next;
    cst_pkg::cmd_e_t      cmd_reg;
    logic [3:0]           idx_reg;
    logic [4:0]           pid_reg;
    logic [COUNT_BITS-1:0] ival_reg;

    // results of the evaluation cycle
    logic err_reg, err_next;
    logic blocked_reg, blocked_next;
    logic wake_reg, wake_next;
    logic init_ok_reg, init_ok_next;
    logic reclaim_ok_reg, reclaim_ok_next;
    logic row_we_reg, row_we_next;
    logic wait_we_reg, wait_we_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    row_t               row_wdata_reg, row_wdata_next;
    logic [WAIT_AW-1:0] wait_waddr_reg, wait_waddr_next;

    // output word register
    logic       m_valid_reg, m_valid_next;
    logic       m_status_reg;
    logic [3:0] m_assigned_index_reg;
    logic       m_blocked_reg;
    logic       m_woken_valid_reg;
    logic [4:0] m_woken_process_reg;

    logic accept, eval_en, out_load;
    logic [ROW_W-1:0] row_rdata;
    logic [PID_W-1:0] wait_rdata;
    row_t             row_rd;
    logic [SLOT_W-1:0] idx_slot;
    logic [PID_W-1:0]  pid_bit;
    logic idx_ok, pid_ok, owned;
    logic signed [CNT_W-1:0] cnt_up, cnt_dn, max_ext;
    logic [PID_W-1:0] head_nx, tail_nx;

    cst_pkg::alloc_req_t  alloc_req;
    cst_pkg::alloc_stat_t alloc_stat;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cst_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = cst_pkg::ST_EVAL;
                end
            end
            cst_pkg::ST_EVAL: begin
                state_next = cst_pkg::ST_DONE;
            end
            cst_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = cst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cst_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        eval_en  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            cst_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            cst_pkg::ST_EVAL: begin
                eval_en = 1'b1;
            end
            cst_pkg::ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // command word capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= cst_pkg::cmd_e_t'(s_cmd);
            idx_reg  <= s_sem_index;
            pid_reg  <= s_process_id;
            ival_reg <= COUNT_BITS'(s_init_value);
        end
    end

    // slot rows: count, maximum, queue pointers, owner bits
    cst_ram #(
        .DEPTH (ROW_DEPTH),
        .WIDTH (ROW_W)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (out_load && row_we_reg),
        .wr_addr (slot_reg),
        .wr_data (row_wdata_reg),
        .rd_en   (accept),
        .rd_addr (SLOT_W'(s_sem_index)),
        .rd_data (row_rdata)
    );

    // wait queues, one ring per slot
    cst_ram #(
        .DEPTH (WAIT_DEPTH),
        .WIDTH (PID_W)
    ) u_wait_ram (
        .aclk    (aclk),
        .wr_en   (out_load && wait_we_reg),
        .wr_addr (wait_waddr_reg),
        .wr_data (PID_W'(pid_reg)),
        .rd_en   (eval_en),
        .rd_addr ({idx_slot, row_rd.head}),
        .rd_data (wait_rdata)
    );

    // slot valid bits and free slot search
    assign alloc_req.set   = out_load && init_ok_reg;
    assign alloc_req.clr   = out_load && reclaim_ok_reg;
    assign alloc_req.slot  = cst_pkg::SLOT_MAX_W'(slot_reg);
    assign alloc_req.query = cst_pkg::SLOT_MAX_W'(idx_reg);

    cst_alloc #(
        .NUM_SEMS (NUM_SEMS)
    ) u_alloc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alloc_req),
        .stat    (alloc_stat)
    );

    // fields of the addressed row
    assign row_rd   = row_t'(row_rdata);
    assign idx_slot = SLOT_W'(idx_reg);
    assign pid_bit  = PID_W'(pid_reg);
    assign idx_ok   = alloc_stat.hit;
    assign pid_ok   = 32'(pid_reg) < NUM_PROCS;
    assign owned    = pid_ok && row_rd.owners[pid_bit];
    assign cnt_up   = row_rd.count + CNT_ONE;
    assign cnt_dn   = row_rd.count - CNT_ONE;
    assign max_ext  = signed'(CNT_W'(row_rd.max));
    assign head_nx  = (row_rd.head == PTR_LAST) ? '0 : row_rd.head + PID_W'(1);
    assign tail_nx  = (row_rd.tail == PTR_LAST) ? '0 : row_rd.tail + PID_W'(1);

    // command evaluation on the read row
    always_comb begin
        err_next        = 1'b1;
        blocked_next    = 1'b0;
        wake_next       = 1'b0;
        init_ok_next    = 1'b0;
        reclaim_ok_next = 1'b0;
        row_we_next     = 1'b0;
        wait_we_next    = 1'b0;
        slot_next       = idx_slot;
        row_wdata_next  = row_rd;
        wait_waddr_next = {idx_slot, row_rd.tail};
        case (cmd_reg)
            cst_pkg::CMD_INIT: begin
                if (!alloc_stat.full) begin
                    err_next              = 1'b0;
                    init_ok_next          = 1'b0 | 1'b1;
                    row_we_next           = 1'b1;
                    slot_next             = SLOT_W'(alloc_stat.free_slot);
                    row_wdata_next.count  = signed'(CNT_W'(ival_reg));
                    row_wdata_next.max    = ival_reg;
                    row_wdata_next.head   = '0;
                    row_wdata_next.tail   = '0;
                    row_wdata_next.owners = '0;
                end
            end
            cst_pkg::CMD_RECLAIM: begin
                if (idx_ok && (row_rd.count == max_ext)) begin
                    err_next        = 1'b0;
                    reclaim_ok_next = 1'b1;
                end
            end
            cst_pkg::CMD_UP: begin
                if (idx_ok && owned) begin
                    err_next    = 1'b0;
                    row_we_next = 1'b1;
                    if (row_rd.count < 0) begin
                        wake_next           = 1'b1;
                        row_wdata_next.head = head_nx;
                    end
                    row_wdata_next.count           = cnt_up;
                    row_wdata_next.owners[pid_bit] = 1'b0;
                end
            end
            cst_pkg::CMD_DOWN: begin
                if (idx_ok && pid_ok && !owned) begin
                    err_next    = 1'b0;
                    row_we_next = 1'b1;
                    row_wdata_next.count           = cnt_dn;
                    row_wdata_next.owners[pid_bit] = 1'b1;
                    if (cnt_dn < 0) begin
                        blocked_next        = 1'b1;
                        wait_we_next        = 1'b1;
                        row_wdata_next.tail = tail_nx;
                    end
                end
            end
            default: begin
                err_next = 1'b1;
            end
        endcase
    end

    // evaluation results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_ok_reg    <= 1'b0;
            reclaim_ok_reg <= 1'b0;
            row_we_reg     <= 1'b0;
            wait_we_reg    <= 1'b0;
        end else if (eval_en) begin
            init_ok_reg    <= init_ok_next;
            reclaim_ok_reg <= reclaim_ok_next;
            row_we_reg     <= row_we_next;
            wait_we_reg    <= wait_we_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_en) begin
            err_reg        <= err_next;
            blocked_reg    <= blocked_next;
            wake_reg       <= wake_next;
            slot_reg       <= slot_next;
            row_wdata_reg  <= row_wdata_next;
            wait_waddr_reg <= wait_waddr_next;
        end
    end

    // output word valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // output word payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg         <= err_reg;
            m_assigned_index_reg <= init_ok_reg ? 4'(slot_reg) : 4'd0;
            m_blocked_reg        <= blocked_reg;
            m_woken_valid_reg    <= wake_reg;
            m_woken_process_reg  <= wake_reg ? 5'(wait_rdata) : 5'd0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_assigned_index = m_assigned_index_reg;
    assign m_blocked        = m_blocked_reg;
    assign m_woken_valid    = m_woken_valid_reg;
    assign m_woken_process  = m_woken_process_reg;

    // checks
    `CST_ASSERT_IMP(a_blocked_clean, aclk, aresetn, m_valid_reg && m_blocked_reg, !m_status_reg && !m_woken_valid_reg, "blocked word carries an error or a wake")
    `CST_ASSERT_IMP(a_wake_clean, aclk, aresetn, m_valid_reg && m_woken_valid_reg, !m_status_reg && (m_assigned_index_reg == 4'd0), "wake word carries an error or a slot")
    `CST_ASSERT_NXT(a_accept_eval, aclk, aresetn, s_valid && s_ready, state_reg == cst_pkg::ST_EVAL, "accepted word not evaluated next cycle")
    `CST_ASSERT_IMP(a_out_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == cst_pkg::ST_DONE), "result word raised outside the done state")
    `CST_ASSERT_IMP(a_alloc_excl, aclk, aresetn, alloc_req.set, !alloc_req.clr, "slot set and cleared together")

endmodule
